### sv/lsno_pkg.sv
`timescale 1ns / 1ps

package lsno_pkg;

    // Fixed field widths of the item and result formats
    localparam int RANGE_W = 16;
    localparam int ANGLE_W = 16;
    localparam int SPEED_W = 12;
    localparam int IDX_W   = 10;
    localparam int POS_W   = 17;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;

    // Scan and rotation sizing
    localparam int MAX_BEAMS    = 1024;
    localparam int BEAM_CNT_W   = $clog2(MAX_BEAMS + 1);
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed-point datapath widths
    localparam int VEC_W  = 36;
    localparam int ZACC_W = 33;
    localparam int PROD_W = 46;
    localparam int GAIN_W = 30;

    localparam logic [GAIN_W-1:0] CORDIC_GAIN = 30'd652032874;
    localparam logic signed [ANGLE_W:0] PI_Q13      = 17'sd25736;
    localparam logic signed [ANGLE_W:0] HALF_PI_Q13 = 17'sd12868;

    localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
        30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
        30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
        30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
        30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
        30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
    };

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_FLOOR   = 3'd0,
        REG_RANGE_CEILING = 3'd1,
        REG_START_ANGLE   = 3'd2,
        REG_ANGLE_STEP    = 3'd3,
        REG_CRUISE_SPEED  = 3'd4,
        REG_STOP_DISTANCE = 3'd5
    } cfg_reg_t;

    // Item kinds
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_EVENT  = 1'b1;

    typedef struct packed {
        logic [RANGE_W-1:0] range_floor;
        logic [RANGE_W-1:0] range_ceiling;
        logic [ANGLE_W-1:0] start_angle;
        logic [ANGLE_W-1:0] angle_step;
        logic [SPEED_W-1:0] cruise_speed;
        logic [RANGE_W-1:0] stop_distance;
    } cfg_t;

    // One finished scan, handed from the search to the rotation unit
    typedef struct packed {
        logic [RANGE_W-1:0] best_range;
        logic [ANGLE_W-1:0] best_angle;
        logic [IDX_W-1:0]   best_index;
        logic               any_valid;
        logic               halted;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### sv/lsno_front.sv
`timescale 1ns / 1ps

module lsno_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lsno_pkg::cfg_t       cfg,
    input  logic                 accept,
    input  logic                 command,
    input  logic [15:0]          range_sample,
    input  logic                 last_sample,
    input  logic                 halt,
    output logic                 push,
    output lsno_pkg::job_t       push_job
);
    import lsno_pkg::*;

    logic [RANGE_W-1:0]    best_range_reg, best_range_next;
    logic [IDX_W-1:0]      best_index_reg, best_index_next;
    logic [ANGLE_W-1:0]    best_angle_reg, best_angle_next;
    logic [ANGLE_W-1:0]    beam_angle_reg, beam_angle_next;
    logic [BEAM_CNT_W-1:0] beam_cnt_reg, beam_cnt_next;
    logic                  any_valid_reg, any_valid_next;
    logic                  halted_reg, halted_next;

    logic [ANGLE_W-1:0]    cur_angle;
    logic                  in_window;
    logic                  take;
    logic                  is_sample;

    assign is_sample = accept && (command == CMD_SAMPLE);
    // beam 0 reads the start angle live
    assign cur_angle = (beam_cnt_reg == '0) ? cfg.start_angle : beam_angle_reg;
    assign in_window = (range_sample >= cfg.range_floor) && (range_sample <= cfg.range_ceiling);
    assign take = (beam_cnt_reg < BEAM_CNT_W'(MAX_BEAMS)) && in_window
                  && (range_sample < best_range_reg);

    always_comb
    begin
        best_range_next = best_range_reg;
        best_index_next = best_index_reg;
        best_angle_next = best_angle_reg;
        beam_angle_next = beam_angle_reg;
        beam_cnt_next   = beam_cnt_reg;
        any_valid_next  = any_valid_reg;
        halted_next     = halted_reg;
        if (accept && (command == CMD_EVENT))
        begin
            halted_next = halt;
        end
        if (is_sample)
        begin
            if (take)
            begin
                best_range_next = range_sample;
                best_index_next = IDX_W'(beam_cnt_reg);
                best_angle_next = cur_angle;
                any_valid_next  = 1'b1;
            end
            if (beam_cnt_reg < BEAM_CNT_W'(MAX_BEAMS))
            begin
                beam_cnt_next = beam_cnt_reg + 1'b1;
            end
            beam_angle_next = cur_angle + cfg.angle_step;
        end
    end

    assign push = is_sample && last_sample;
    assign push_job = '{best_range: best_range_next, best_angle: best_angle_next,
                        best_index: best_index_next, any_valid: any_valid_next,
                        halted: halted_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_range_reg <= '1;
            best_index_reg <= '0;
            best_angle_reg <= '0;
            beam_angle_reg <= '0;
            beam_cnt_reg   <= '0;
            any_valid_reg  <= 1'b0;
            halted_reg     <= 1'b0;
        end
        else if (push)
        begin
            // end of scan: start over, keep the halt flag
            best_range_reg <= '1;
            best_index_reg <= '0;
            best_angle_reg <= '0;
            beam_angle_reg <= '0;
            beam_cnt_reg   <= '0;
            any_valid_reg  <= 1'b0;
            halted_reg     <= halted_next;
        end
        else
        begin
            best_range_reg <= best_range_next;
            best_index_reg <= best_index_next;
            best_angle_reg <= best_angle_next;
            beam_angle_reg <= beam_angle_next;
            beam_cnt_reg   <= beam_cnt_next;
            any_valid_reg  <= any_valid_next;
            halted_reg     <= halted_next;
        end
    end

endmodule

### sv/lsno_queue.sv
`timescale 1ns / 1ps

module lsno_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  lsno_pkg::job_t           push_job,
    input  logic                     pop,
    output lsno_pkg::job_t           pop_job,
    output lsno_pkg::queue_status_t  status
);
    import lsno_pkg::*;

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### sv/lsno_back.sv
`timescale 1ns / 1ps

module lsno_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lsno_pkg::cfg_t           cfg,
    input  lsno_pkg::queue_status_t  q_status,
    input  lsno_pkg::job_t           q_job,
    output logic                     pop,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [79:0]              m_tdata
);
    import lsno_pkg::*;

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_MUL  = 5'b00010,
        B_INIT = 5'b00100,
        B_ROT  = 5'b01000,
        B_DONE = 5'b10000
    } back_state_t;

    back_state_t                state_reg, state_next;
    job_t                       job_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic                       neg_reg;
    logic signed [VEC_W-1:0]    x_reg, y_reg;
    logic signed [ZACC_W-1:0]   z_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       out_valid_reg;
    logic [OUT_DATA_W-1:0]      out_data_reg;

    logic signed [ANGLE_W:0]    ang_wide, ang_red;
    logic                       ang_neg;
    logic signed [VEC_W-1:0]    x_start, dx, dy;
    logic signed [ZACC_W-1:0]   atan_val;
    logic                       out_free;
    logic signed [VEC_W-1:0]    x_round, y_round;
    logic signed [POS_W-1:0]    x_sat, y_sat, x_res, y_res;
    logic                       alert;
    logic [ANGLE_W-1:0]         turn;
    logic [SPEED_W-1:0]         speed;

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [VEC_W-1:0] v);
        logic signed [VEC_W-1:0] hi, lo;
        hi = VEC_W'(65535);
        lo = -VEC_W'(65536);
        if (v > hi)
            return POS_W'(hi);
        else if (v < lo)
            return POS_W'(lo);
        else
            return POS_W'(v);
    endfunction

    assign pop      = (state_reg == B_IDLE) && !q_status.empty;
    assign out_free = !out_valid_reg || m_tready;

    // fold angles beyond +-pi/2 by a half turn
    assign ang_wide = {job_reg.best_angle[ANGLE_W-1], job_reg.best_angle};
    always_comb
    begin
        ang_red = ang_wide;
        ang_neg = 1'b0;
        if (ang_wide > HALF_PI_Q13)
        begin
            ang_red = ang_wide - PI_Q13;
            ang_neg = 1'b1;
        end
        else if (ang_wide < -HALF_PI_Q13)
        begin
            ang_red = ang_wide + PI_Q13;
            ang_neg = 1'b1;
        end
    end

    assign x_start  = VEC_W'(prod_reg >> 14);
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = ZACC_W'(ATAN_Q30[ATAN_IDX_W'(step_reg)]);

    // round half up, saturate, and apply the empty-scan answer
    assign x_round = (x_reg + VEC_W'(32768)) >>> 16;
    assign y_round = (y_reg + VEC_W'(32768)) >>> 16;
    assign x_sat   = sat_pos(x_round);
    assign y_sat   = sat_pos(y_round);
    assign x_res   = job_reg.any_valid ? x_sat : POS_W'(65535);
    assign y_res   = job_reg.any_valid ? y_sat : '0;
    assign alert   = ($signed({x_res[POS_W-1], x_res}) < $signed({2'b00, cfg.stop_distance}))
                  && ($signed({y_res[POS_W-1], y_res}) < $signed({2'b00, cfg.stop_distance}));

    always_comb
    begin
        if (job_reg.halted || !job_reg.any_valid)
            turn = '0;
        else if (job_reg.best_angle == {1'b1, {(ANGLE_W-1){1'b0}}})
            turn = {1'b0, {(ANGLE_W-1){1'b1}}};
        else
            turn = -job_reg.best_angle;
    end
    assign speed = job_reg.halted ? '0 : cfg.cruise_speed;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE: if (!q_status.empty) state_next = B_MUL;
            B_MUL:  state_next = B_INIT;
            B_INIT: state_next = B_ROT;
            B_ROT:  if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = B_DONE;
            B_DONE: if (out_free) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == B_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                    job_reg <= q_job;
            end
            B_MUL:
            begin
                prod_reg <= PROD_W'(job_reg.best_range) * PROD_W'(CORDIC_GAIN);
                neg_reg  <= ang_neg;
                z_reg    <= ZACC_W'(ang_red) <<< 17;
            end
            B_INIT:
            begin
                x_reg    <= neg_reg ? -x_start : x_start;
                y_reg    <= '0;
                step_reg <= '0;
            end
            B_ROT:
            begin
                if (!z_reg[ZACC_W-1])
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan_val;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan_val;
                end
                step_reg <= step_reg + 1'b1;
            end
            B_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= {6'd0, job_reg.any_valid,
                                     job_reg.any_valid ? job_reg.best_index : IDX_W'(0),
                                     alert, y_res, x_res, turn, speed};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sv/laser_scan_nearest_obstacle_steer.sv
`timescale 1ns / 1ps

// Nearest obstacle search and steering command for one lidar scan.
//
// Input channel s_*: one item per beam or per start/stop event.
//   s_tuser is the kind: 0 range sample, 1 start/stop event.
//   s_tdata[15:0] range sample (1/1024 m), s_tdata[16] halt flag for events.
//   s_tlast marks the final sample of a scan.
// Output channel m_*: one item per scan, issued for the sample with s_tlast.
// Config port: cfg_we writes cfg_data into register cfg_index.
//
// The search part takes one item per clock while the two-entry scan queue
// has room. The rotation unit runs a 16-step CORDIC, one step a clock, and
// works on one scan at a time; scans that finish while it is busy back up
// into the queue, and a full queue holds s_tready low.
//
// Reset clears the scan state, the halt flag and the queue, and loads
// the default register values. When the receiver stalls, the result
// stays in the output register, the next scan waits in the rotation unit,
// and s_tready drops once the queue is full.
module laser_scan_nearest_obstacle_steer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] range_sample, [16] halt, [23:17] zero
    input  logic        s_tuser,   // [0] command
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [11:0] drive_speed, [27:12] turn_rate, [44:28] obstacle_x,
    // [61:45] obstacle_y, [62] stop_alert, [72:63] nearest_index,
    // [73] found, [79:74] zero
    output logic [79:0] m_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import lsno_pkg::*;

    cfg_t          cfg_reg;
    logic          accept;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          pop_job;
    queue_status_t q_status;

    // Register file; the user must write only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_floor   <= 16'd0;
            cfg_reg.range_ceiling <= 16'd65534;
            cfg_reg.start_angle   <= 16'h9B78;   // -25736, i.e. -pi
            cfg_reg.angle_step    <= 16'd36;
            cfg_reg.cruise_speed  <= 12'd1024;
            cfg_reg.stop_distance <= 16'd614;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANGE_FLOOR:   cfg_reg.range_floor   <= cfg_data;
                REG_RANGE_CEILING: cfg_reg.range_ceiling <= cfg_data;
                REG_START_ANGLE:   cfg_reg.start_angle   <= cfg_data;
                REG_ANGLE_STEP:    cfg_reg.angle_step    <= cfg_data;
                REG_CRUISE_SPEED:  cfg_reg.cruise_speed  <= cfg_data[SPEED_W-1:0];
                REG_STOP_DISTANCE: cfg_reg.stop_distance <= cfg_data;
                default: ;   // drop writes beyond the register list
            endcase
        end
    end

    // Hold off new items whenever the scan queue is full
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    lsno_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .accept       (accept),
        .command      (s_tuser),
        .range_sample (s_tdata[15:0]),
        .last_sample  (s_tlast),
        .halt         (s_tdata[16]),
        .push         (push),
        .push_job     (push_job)
    );

    lsno_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .status   (q_status)
    );

    lsno_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .q_job    (pop_job),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### sv/lsno_checker.sv
`timescale 1ns / 1ps

module lsno_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // and keeps its contents
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // an empty scan reports the far point straight ahead
    a_empty_scan: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[73] |->
            m_tdata[44:28] == 17'h0FFFF && m_tdata[61:45] == 17'h00000
            && m_tdata[72:63] == 10'd0 && !m_tdata[62] && m_tdata[27:12] == 16'h0000)
        else $error("empty scan result malformed");

    // negating the angle saturates
    a_turn_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[27:12] != 16'h8000)
        else $error("turn rate not saturated");

endmodule

bind laser_scan_nearest_obstacle_steer lsno_checker u_lsno_checker (.*);
